>>> src/assert_macros.svh
// assertion macros shared by the state memory and the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define CWDA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define CWDA_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/cwda_pkg.sv
// types, constants and codes of the counter wrap delta accumulator
package cwda_pkg;

	// number of counter channels held in the state memory
	localparam int CHANNELS = 4;
	localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// fixed field widths
	localparam int CHAN_W  = 2;
	localparam int RAW_W   = 24;
	localparam int VAL_W   = 25;
	localparam int TOT_W   = 32;
	localparam int MASK_W  = 4;
	localparam int LIMIT_W = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int DIFF_W  = 26;

	// wrap correction thresholds and spans
	localparam logic signed [DIFF_W-1:0] LIM16  = 26'sd32767;
	localparam logic signed [DIFF_W-1:0] SPAN16 = 26'sd65536;
	localparam logic signed [DIFF_W-1:0] LIM24  = 26'sd8388607;
	localparam logic signed [DIFF_W-1:0] SPAN24 = 26'sd16777216;

	localparam logic [LIMIT_W-1:0] ERR_MAX = 16'hFFFF;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_MASK   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDE_MASK     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ABSOLUTE_MASK = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SOFT_LIMIT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HARD_LIMIT    = 3'd4;

	// result status codes
	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_SKIP = 2'd1,
		STAT_ERR  = 2'd2,
		STAT_HARD = 2'd3
	} status_t;

	typedef struct packed {
		logic [CHAN_W-1:0] channel;
		logic [RAW_W-1:0]  raw_value;
		logic              read_failed;
	} reading_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] counter_value;
		logic [TOT_W-1:0]        absolute_total;
		status_t                 status;
		logic                    soft_limit_hit;
	} result_t;

	// per channel entry of the state memory
	typedef struct packed {
		logic [RAW_W-1:0] prev;
		logic             first;
		logic [TOT_W-1:0] total;
	} entry_t;

	localparam entry_t ENTRY_RESET = '{prev: '0, first: 1'b1, total: '0};

	// write-back request into the state memory
	typedef struct packed {
		logic            en;
		logic [CH_W-1:0] addr;
		entry_t          data;
	} mem_wr_t;

endpackage

>>> src/cwda_state_mem.sv
// per channel state memory with registered read, valid bits and write forwarding
module cwda_state_mem (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [cwda_pkg::CH_W-1:0] rd_addr,
	input  cwda_pkg::mem_wr_t wr,
	output cwda_pkg::entry_t rd_data
);
	import cwda_pkg::*;

	`include "assert_macros.svh"

	entry_t             mem [CHANNELS];
	logic [CHANNELS-1:0] valid_q;
	entry_t             rdata_q;
	logic               rvalid_q;
	logic               fwd_q;
	entry_t             fwd_data_q;

	// memory array write
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// entry valid bits, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.addr] <= 1'b1;
		end
	end

	// registered read, with bypass of a write to the same entry in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvalid_q <= 1'b0;
			fwd_q    <= 1'b0;
		end else if (rd_en) begin
			rvalid_q <= valid_q[rd_addr];
			fwd_q    <= wr.en && (wr.addr == rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q    <= mem[rd_addr];
			fwd_data_q <= wr.data;
		end
	end

	// read data select: forwarded write, unwritten entry or stored entry
	always_comb begin
		if (fwd_q) begin
			rd_data = fwd_data_q;
		end else if (!rvalid_q) begin
			rd_data = ENTRY_RESET;
		end else begin
			rd_data = rdata_q;
		end
	end

	`CWDA_ASSERT(a_wr_sets_valid, wr.en |=> valid_q[$past(wr.addr)], "written entry not marked valid")
	`CWDA_ASSERT(a_fwd_on_collision, (rd_en && wr.en && (wr.addr == rd_addr)) |=> fwd_q, "read of entry under write not forwarded")
	`CWDA_ASSERT_ALWAYS(a_valid_reset, !arst_n |=> (valid_q == '0), "valid bits not cleared in reset")

endmodule

>>> src/cwda_update.sv
// per item datapath: conversion, wrap correction, accumulation and error counting
module cwda_update (
	input  cwda_pkg::reading_t             item,
	input  cwda_pkg::entry_t               entry,
	input  logic [cwda_pkg::MASK_W-1:0]    enable_mask,
	input  logic [cwda_pkg::MASK_W-1:0]    wide_mask,
	input  logic [cwda_pkg::MASK_W-1:0]    absolute_mask,
	input  logic [cwda_pkg::LIMIT_W-1:0]   error_soft_limit,
	input  logic [cwda_pkg::LIMIT_W-1:0]   error_hard_limit,
	input  logic [cwda_pkg::LIMIT_W-1:0]   err_count,
	output cwda_pkg::result_t              res,
	output cwda_pkg::mem_wr_t              wr,
	output logic                           err_upd,
	output logic [cwda_pkg::LIMIT_W-1:0]   err_next
);
	import cwda_pkg::*;

	logic                     ch_ok;
	logic                     en;
	logic                     wide;
	logic                     absolute;
	logic signed [VAL_W-1:0]  cur;
	logic signed [VAL_W-1:0]  old;
	logic signed [DIFF_W-1:0] diff_raw;
	logic signed [DIFF_W-1:0] diff_fix;
	logic signed [DIFF_W-1:0] lim;
	logic signed [DIFF_W-1:0] span;
	logic [TOT_W-1:0]         total_new;
	logic [RAW_W-1:0]         prev_new;
	logic                     err_sat;

	assign ch_ok    = 32'(item.channel) < CHANNELS;
	assign en       = enable_mask[item.channel];
	assign wide     = wide_mask[item.channel];
	assign absolute = absolute_mask[item.channel];

	// reading and previous reading in the channel's counter mode
	always_comb begin
		if (wide) begin
			cur  = $signed({1'b0, item.raw_value});
			old  = $signed({1'b0, entry.prev});
			lim  = LIM24;
			span = SPAN24;
		end else begin
			cur  = $signed({{(VAL_W-16){item.raw_value[15]}}, item.raw_value[15:0]});
			old  = $signed({{(VAL_W-16){entry.prev[15]}}, entry.prev[15:0]});
			lim  = LIM16;
			span = SPAN16;
		end
		if (entry.first) begin
			old = cur;
		end
	end

	// wrap-corrected difference and new total
	always_comb begin
		diff_raw = {cur[VAL_W-1], cur} - {old[VAL_W-1], old};
		if (diff_raw < -lim) begin
			diff_fix = diff_raw + span;
		end else if (diff_raw > lim) begin
			diff_fix = diff_raw - span;
		end else begin
			diff_fix = diff_raw;
		end
		total_new = entry.total + {{(TOT_W-DIFF_W){diff_fix[DIFF_W-1]}}, diff_fix};
		if (absolute || entry.first) begin
			prev_new = cur[RAW_W-1:0];
		end else begin
			prev_new = entry.prev;
		end
	end

	// saturating error count
	assign err_sat  = (err_count == ERR_MAX);
	assign err_next = err_sat ? err_count : err_count + 16'd1;
	assign err_upd  = ch_ok && en && item.read_failed;

	// result and state write-back
	always_comb begin
		res.counter_value  = '0;
		res.absolute_total = ch_ok ? entry.total : '0;
		res.status         = STAT_SKIP;
		res.soft_limit_hit = 1'b0;
		wr.en              = 1'b0;
		wr.addr            = CH_W'(item.channel);
		wr.data.prev       = prev_new;
		wr.data.first      = 1'b0;
		wr.data.total      = absolute ? total_new : entry.total;
		if (ch_ok && en) begin
			if (item.read_failed) begin
				res.status         = (err_next >= error_hard_limit) ? STAT_HARD : STAT_ERR;
				res.soft_limit_hit = !err_sat && (err_next == error_soft_limit);
			end else begin
				wr.en              = 1'b1;
				res.counter_value  = cur;
				res.absolute_total = wr.data.total;
				res.status         = STAT_OK;
			end
		end
	end

endmodule

>>> src/counter_wrap_delta_accumulator.sv
// top level of the counter wrap delta accumulator
//
// channel   direction  handshake                          payload
// reading   in         reading_valid / reading_ready      reading (channel, raw_value, read_failed)
// result    out        result_valid / result_ready        result (value, total, status, soft hit)
// cfg       in         cfg_wr_en, no wait                 cfg_index, cfg_data
//
// one reading per cycle unless the output stalls; a result passes stage 1 and the output register
// the accepting edge registers the channel entry read from the state memory; as stage 1
// advances it updates, writes back and loads the output register; a write to the entry being
// read is forwarded
// reset clears the valid bits of the memory, so unwritten entries read as reset state
// a stalled result holds stage 1; a new reading is taken while the output is freed
module counter_wrap_delta_accumulator (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 reading_valid,
	output logic                 reading_ready,
	input  cwda_pkg::reading_t   reading,
	output logic                 result_valid,
	input  logic                 result_ready,
	output cwda_pkg::result_t    result,
	input  logic                 cfg_wr_en,
	input  logic [cwda_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cwda_pkg::CFG_DATA_W-1:0] cfg_data
);
	import cwda_pkg::*;

	`include "assert_macros.svh"

	logic [MASK_W-1:0]  enable_mask_q;
	logic [MASK_W-1:0]  wide_mask_q;
	logic [MASK_W-1:0]  absolute_mask_q;
	logic [LIMIT_W-1:0] soft_limit_q;
	logic [LIMIT_W-1:0] hard_limit_q;
	logic [LIMIT_W-1:0] err_count_q;

	logic               valid_s1;
	reading_t           item_s1;
	logic               out_valid_q;
	result_t            out_q;

	logic               in_fire;
	logic               adv_s1;
	entry_t             entry;
	result_t            res;
	mem_wr_t            upd_wr;
	mem_wr_t            mem_wr;
	logic               err_upd;
	logic [LIMIT_W-1:0] err_next;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_mask_q   <= 4'd15;
			wide_mask_q     <= 4'd15;
			absolute_mask_q <= 4'd0;
			soft_limit_q    <= 16'd25;
			hard_limit_q    <= 16'd50;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_ENABLE_MASK:   enable_mask_q   <= cfg_data[MASK_W-1:0];
				CFG_WIDE_MASK:     wide_mask_q     <= cfg_data[MASK_W-1:0];
				CFG_ABSOLUTE_MASK: absolute_mask_q <= cfg_data[MASK_W-1:0];
				CFG_SOFT_LIMIT:    soft_limit_q    <= cfg_data[LIMIT_W-1:0];
				CFG_HARD_LIMIT:    hard_limit_q    <= cfg_data[LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// handshake and stage advance
	assign adv_s1        = valid_s1 && (!out_valid_q || result_ready);
	assign reading_ready = !valid_s1 || adv_s1;
	assign in_fire       = reading_valid && reading_ready;

	// stage 1 holds the item while its entry is read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (reading_ready) begin
			valid_s1 <= reading_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1 <= reading;
		end
	end

	// write back only when the item leaves stage 1
	always_comb begin
		mem_wr    = upd_wr;
		mem_wr.en = upd_wr.en && adv_s1;
	end

	cwda_state_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_fire),
		.rd_addr (CH_W'(reading.channel)),
		.wr      (mem_wr),
		.rd_data (entry)
	);

	cwda_update u_update (
		.item             (item_s1),
		.entry            (entry),
		.enable_mask      (enable_mask_q),
		.wide_mask        (wide_mask_q),
		.absolute_mask    (absolute_mask_q),
		.error_soft_limit (soft_limit_q),
		.error_hard_limit (hard_limit_q),
		.err_count        (err_count_q),
		.res              (res),
		.wr               (upd_wr),
		.err_upd          (err_upd),
		.err_next         (err_next)
	);

	// shared error counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_count_q <= '0;
		end else if (adv_s1 && err_upd) begin
			err_count_q <= err_next;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_q <= res;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	`CWDA_ASSERT(a_err_monotonic, err_count_q >= $past(err_count_q), "error count decreased")
	`CWDA_ASSERT(a_stall_reason, !reading_ready |-> (valid_s1 && out_valid_q && !result_ready), "input stalled without a full pipeline")
	`CWDA_ASSERT(a_soft_hit_on_error, (out_valid_q && out_q.soft_limit_hit) |-> (out_q.status == STAT_ERR || out_q.status == STAT_HARD), "soft limit hit without a read error")
	`CWDA_ASSERT(a_write_on_advance, mem_wr.en |-> (adv_s1 && !item_s1.read_failed), "state written without a good reading leaving stage 1")

endmodule

>>> sim/tb_top.sv
// self-checking testbench of the counter wrap delta accumulator
`timescale 1ns / 100ps

module tb_top;
	import cwda_pkg::*;

	logic                  clk;
	logic                  arst_n        = 1'b0;
	logic                  reading_valid = 1'b0;
	logic                  reading_ready;
	reading_t              reading       = '0;
	logic                  result_valid;
	logic                  result_ready  = 1'b0;
	result_t               result;
	logic                  cfg_wr_en     = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index     = '0;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;

	// idle chances of sender and receiver, in percent
	int send_idle_pct = 21;
	int recv_idle_pct = 46;
	int mismatch_count = 0;

	// predicted register settings and channel state
	logic [MASK_W-1:0]  en_mask;
	logic [MASK_W-1:0]  wide_sel;
	logic [MASK_W-1:0]  abs_mask;
	logic [LIMIT_W-1:0] soft_lim;
	logic [LIMIT_W-1:0] hard_lim;
	logic [LIMIT_W-1:0] err_cnt;
	logic [RAW_W-1:0]   prev_read [CHANNELS];
	logic               first_read [CHANNELS];
	logic [TOT_W-1:0]   totals [CHANNELS];

	// results expected from accepted readings, oldest first
	result_t pending_results [$];

	counter_wrap_delta_accumulator uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.reading_valid (reading_valid),
		.reading_ready (reading_ready),
		.reading       (reading),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.result        (result),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	initial begin
		#3_000_000;
		$display("FAIL counter_wrap_delta_accumulator");
		$finish;
	end

	// result of one reading, advancing the predicted state
	function automatic result_t accumulate_reading(reading_t rd);
		result_t res;
		int ch;
		int cur;
		int old;
		int diff;
		int lim;
		int span;
		ch = rd.channel;
		res.counter_value  = '0;
		res.absolute_total = totals[ch];
		res.status         = STAT_SKIP;
		res.soft_limit_hit = 1'b0;
		if (!en_mask[ch])
			return res;
		// failed read only moves the shared error counter
		if (rd.read_failed) begin
			if (err_cnt != ERR_MAX) begin
				err_cnt++;
				res.soft_limit_hit = (err_cnt == soft_lim);
			end
			res.status = (err_cnt >= hard_lim) ? STAT_HARD : STAT_ERR;
			return res;
		end
		if (wide_sel[ch]) begin
			cur  = int'(rd.raw_value);
			old  = int'(prev_read[ch]);
			lim  = 8388607;
			span = 16777216;
		end else begin
			cur  = int'($signed(rd.raw_value[15:0]));
			old  = int'($signed(prev_read[ch][15:0]));
			lim  = 32767;
			span = 65536;
		end
		// first good reading gives a zero difference
		if (first_read[ch]) begin
			old = cur;
			prev_read[ch] = cur[RAW_W-1:0];
		end
		// wrap corrected difference into the total
		if (abs_mask[ch]) begin
			diff = cur - old;
			prev_read[ch] = cur[RAW_W-1:0];
			if (diff < -lim)
				diff += span;
			else if (diff > lim)
				diff -= span;
			totals[ch] = totals[ch] + 32'(diff);
		end
		first_read[ch] = 1'b0;
		res.counter_value  = cur[VAL_W-1:0];
		res.absolute_total = totals[ch];
		res.status         = STAT_OK;
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		mismatch_count++;
		$display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
	endtask

	task automatic check_result(result_t got);
		result_t want;
		if (pending_results.size() == 0) begin
			report_mismatch("result with none expected", got.absolute_total, '0);
			return;
		end
		want = pending_results.pop_front();
		if (got.counter_value !== want.counter_value)
			report_mismatch("counter_value", 32'(got.counter_value), 32'(want.counter_value));
		if (got.absolute_total !== want.absolute_total)
			report_mismatch("absolute_total", got.absolute_total, want.absolute_total);
		if (got.status !== want.status)
			report_mismatch("status", 32'(got.status), 32'(want.status));
		if (got.soft_limit_hit !== want.soft_limit_hit)
			report_mismatch("soft_limit_hit", 32'(got.soft_limit_hit), 32'(want.soft_limit_hit));
	endtask

	// result side: check each transaction, stall at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready)
				check_result(result);
			result_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// one reading transaction, with a random gap ahead of it
	task automatic send_reading(logic [CHAN_W-1:0] ch, logic [RAW_W-1:0] raw, logic failed);
		reading_t rd;
		rd.channel     = ch;
		rd.raw_value   = raw;
		rd.read_failed = failed;
		while ($urandom_range(99) < send_idle_pct) begin
			reading_valid <= 1'b0;
			@(posedge clk);
		end
		reading_valid <= 1'b1;
		reading       <= rd;
		do
			@(posedge clk);
		while (!reading_ready);
		pending_results.push_back(accumulate_reading(rd));
	endtask

	// stop sending and let every expected result come out
	task automatic wait_for_results();
		reading_valid <= 1'b0;
		for (int n = 0; n < 10000 && pending_results.size() != 0; n++)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_ENABLE_MASK:   en_mask  = data[MASK_W-1:0];
			CFG_WIDE_MASK:     wide_sel = data[MASK_W-1:0];
			CFG_ABSOLUTE_MASK: abs_mask = data[MASK_W-1:0];
			CFG_SOFT_LIMIT:    soft_lim = data;
			CFG_HARD_LIMIT:    hard_lim = data;
			default: ;
		endcase
	endtask

	// mask with all, none or a random set of channels
	function automatic logic [MASK_W-1:0] pick_mask();
		case ($urandom_range(4))
			0: return '0;
			1: return '1;
			default: return MASK_W'($urandom);
		endcase
	endfunction

	// limit near the current error count, sometimes an extreme
	function automatic logic [LIMIT_W-1:0] pick_limit(int spread);
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return err_cnt + LIMIT_W'($urandom_range(spread));
		endcase
	endfunction

	// reading that mostly follows the channel's counter, sometimes jumps
	function automatic logic [RAW_W-1:0] pick_raw(int ch);
		logic [RAW_W-1:0] val;
		int lim;
		lim = wide_sel[ch] ? 8388607 : 32767;
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: val = prev_read[ch] + RAW_W'($urandom_range(2000)) - 24'd500;
			6: val = prev_read[ch] + RAW_W'(($urandom_range(1) ? lim : -lim)
				+ int'($urandom_range(4)) - 2);
			7, 8: val = RAW_W'($urandom);
			default: begin
				case ($urandom_range(5))
					0: val = 24'h000000;
					1: val = 24'hFFFFFF;
					2: val = 24'h7FFFFF;
					3: val = 24'h800000;
					4: val = 24'h007FFF;
					default: val = 24'h008000;
				endcase
			end
		endcase
		// upper byte is ignored in 16-bit mode
		if (!wide_sel[ch])
			val[RAW_W-1:16] = 8'($urandom);
		return val;
	endfunction

	task automatic randomize_config();
		wait_for_results();
		write_reg(CFG_ENABLE_MASK, ($urandom_range(2) == 0) ? 16'(pick_mask()) : 16'hF);
		write_reg(CFG_WIDE_MASK, 16'(pick_mask()));
		write_reg(CFG_ABSOLUTE_MASK, ($urandom_range(3) == 0) ? 16'(pick_mask()) : 16'hF);
		write_reg(CFG_SOFT_LIMIT, pick_limit(8));
		write_reg(CFG_HARD_LIMIT, pick_limit(16));
	endtask

	// reset register values, first readings and a failed read
	task automatic test_reset_defaults();
		send_reading(2'd0, 24'h000000, 1'b0);
		send_reading(2'd1, 24'hFFFFFF, 1'b0);
		send_reading(2'd0, 24'h123456, 1'b0);
		send_reading(2'd3, 24'hABCDEF, 1'b1);
	endtask

	// 16-bit wrap correction around both thresholds
	task automatic test_narrow_wrap();
		wait_for_results();
		write_reg(CFG_WIDE_MASK, 16'h0);
		write_reg(CFG_ABSOLUTE_MASK, 16'hF);
		send_reading(2'd0, 24'hAB7FFF, 1'b0);
		send_reading(2'd0, 24'h008000, 1'b0);
		send_reading(2'd0, 24'h000000, 1'b0);
		send_reading(2'd1, 24'h000000, 1'b0);
		send_reading(2'd1, 24'hFF8001, 1'b0);
		send_reading(2'd1, 24'h007FFF, 1'b0);
	endtask

	// 24-bit wrap correction around both thresholds
	task automatic test_wide_wrap();
		wait_for_results();
		write_reg(CFG_WIDE_MASK, 16'hF);
		send_reading(2'd2, 24'hFFFFFF, 1'b0);
		send_reading(2'd2, 24'h000000, 1'b0);
		send_reading(2'd2, 24'h800000, 1'b0);
		send_reading(2'd3, 24'h7FFFFF, 1'b0);
		send_reading(2'd3, 24'h000000, 1'b0);
	endtask

	// stored reading reinterpreted after a width change, then absolute mode off
	task automatic test_mode_switch();
		wait_for_results();
		write_reg(CFG_WIDE_MASK, 16'h9);
		send_reading(2'd2, 24'h12FFFF, 1'b0);
		send_reading(2'd0, 24'h000010, 1'b0);
		wait_for_results();
		write_reg(CFG_ABSOLUTE_MASK, 16'h0);
		send_reading(2'd2, 24'h000005, 1'b0);
	endtask

	// disabled channels are skipped, failed reads on them are not counted
	task automatic test_disabled_channels();
		wait_for_results();
		write_reg(CFG_ENABLE_MASK, 16'h0);
		send_reading(2'd0, 24'h00AAAA, 1'b0);
		send_reading(2'd3, 24'h555555, 1'b1);
		wait_for_results();
		write_reg(CFG_ENABLE_MASK, 16'h5);
		send_reading(2'd1, 24'h000001, 1'b0);
		send_reading(2'd2, 24'h000100, 1'b0);
	endtask

	// soft limit hit once, hard limit reached, both limits at zero
	task automatic test_error_limits();
		wait_for_results();
		write_reg(CFG_SOFT_LIMIT, err_cnt + 16'd2);
		write_reg(CFG_HARD_LIMIT, err_cnt + 16'd3);
		repeat (4) send_reading(2'd0, 24'h000000, 1'b1);
		wait_for_results();
		write_reg(CFG_SOFT_LIMIT, 16'h0);
		write_reg(CFG_HARD_LIMIT, 16'h0);
		send_reading(2'd2, 24'hFFFFFF, 1'b1);
	endtask

	// counting sequences with jumps, failures and periodic reconfiguration
	task automatic test_random_counting(int count);
		int done;
		int sent;
		int ch;
		done = 0;
		sent = 0;
		while (done < count) begin
			if (sent % 95 == 0)
				randomize_config();
			ch = $urandom_range(CHANNELS - 1);
			send_reading(CHAN_W'(ch), pick_raw(ch), $urandom_range(99) < 8);
			sent++;
			if (en_mask[ch])
				done++;
		end
	endtask

	// failed reads with both limits at the top count value
	task automatic test_error_top_limits();
		wait_for_results();
		write_reg(CFG_ENABLE_MASK, 16'hF);
		write_reg(CFG_SOFT_LIMIT, 16'hFFFF);
		write_reg(CFG_HARD_LIMIT, 16'hFFFF);
		repeat (3) send_reading(CHAN_W'($urandom), RAW_W'($urandom), 1'b1);
	endtask

	initial begin
		en_mask  = 4'hF;
		wide_sel = 4'hF;
		abs_mask = 4'h0;
		soft_lim = 16'd25;
		hard_lim = 16'd50;
		err_cnt  = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			prev_read[i]  = '0;
			first_read[i] = 1'b1;
			totals[i]     = '0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_narrow_wrap();
		test_wide_wrap();
		test_mode_switch();
		test_disabled_channels();
		test_error_limits();
		test_random_counting(470);

		wait_for_results();
		send_idle_pct = 46;
		recv_idle_pct = 21;
		test_random_counting(470);

		wait_for_results();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_counting(470);
		test_error_top_limits();

		wait_for_results();
		repeat (8) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch("results never arrived", pending_results.size(), '0);
		if (mismatch_count == 0)
			$display("PASS counter_wrap_delta_accumulator");
		else
			$display("FAIL counter_wrap_delta_accumulator");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+src
src/cwda_pkg.sv
src/cwda_state_mem.sv
src/cwda_update.sv
src/counter_wrap_delta_accumulator.sv
sim/tb_top.sv
